// ===== design/cle_pkg.sv =====
// cle_pkg: shared constants and types for the console line editor
// key codes, sequencer states and the result transfer struct
// no dependencies
package cle_pkg;

  localparam int CLE_BUF_DEPTH = 16;

  localparam logic [7:0] KEY_ESC  = 8'h1B;
  localparam logic [7:0] KEY_LBR  = 8'h5B;
  localparam logic [7:0] KEY_LEFT = 8'h44;
  localparam logic [7:0] KEY_RGHT = 8'h43;
  localparam logic [7:0] KEY_BS   = 8'h08;
  localparam logic [7:0] KEY_DEL  = 8'h7F;
  localparam logic [7:0] KEY_CR   = 8'h0D;
  localparam logic [7:0] KEY_NL   = 8'h0A;
  localparam logic [7:0] KEY_EOF  = 8'h04;
  localparam logic [7:0] KEY_KILL = 8'h15;
  localparam logic [7:0] KEY_PROC = 8'h10;
  localparam logic [7:0] KEY_SP   = 8'h20;

  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_LINE = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_EOF  = 2'd3;

  localparam logic TGT_ECHO   = 1'b0;
  localparam logic TGT_READER = 1'b1;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2
  } cle_phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_RDATA, S_CDATA,
    S_INS_RD, S_INS_WR, S_BSN,
    S_BK_RD, S_BK_WR,
    S_RUB1, S_RUB2, S_RUB3,
    S_KILL_RD, S_KILL_EV, S_KILL_CHK, S_KILL_EV2
  } cle_state_t;

  typedef struct packed {
    logic       vld;
    logic       target;
    logic [7:0] data;
    logic [1:0] status;
    logic       last;
  } cle_emit_t;

endpackage

// ===== design/cle_core.sv =====
// cle_core: line editing sequencer around the line store memory
// one read port and one write port, read data registered; uses cle_pkg
module cle_core import cle_pkg::*; #(
  parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       kind,
  input  logic [7:0] key_code,
  input  logic       read_first,
  input  logic       raw_mode,
  input  logic       out_free,
  output logic       idle,
  output cle_emit_t  emit
);

  localparam int PW = $clog2(2 * BUF_DEPTH);
  localparam int AW = $clog2(BUF_DEPTH);

  function automatic logic [PW-1:0] p_adv(input logic [PW-1:0] p);
    return (p == PW'(2 * BUF_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] p_back(input logic [PW-1:0] p);
    return (p == '0) ? PW'(2 * BUF_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] p_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + (PW+1)'(2 * BUF_DEPTH) - {1'b0, b};
    return (a >= b) ? a - b : s[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] p_slot(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    q = p - PW'(BUF_DEPTH);
    return (p >= PW'(BUF_DEPTH)) ? q[AW-1:0] : p[AW-1:0];
  endfunction

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata_r;
  logic       we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  cle_state_t state_r, state_nxt;
  cle_phase_t ph_r, ph_nxt;
  logic [PW-1:0] rd_r, rd_nxt, cm_r, cm_nxt, end_r, end_nxt, cur_r, cur_nxt, w_r, w_nxt;
  logic [PW-1:0] cnt_r, cnt_nxt, bsn_r, bsn_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       kill_r, kill_nxt, first_r, first_nxt;
  cle_emit_t  pend_r, pend_nxt;

  logic       room;
  logic [7:0] k2;
  logic [PW-1:0] e1;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_NORMAL;
      rd_r    <= '0;
      cm_r    <= '0;
      end_r   <= '0;
      cur_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      rd_r    <= rd_nxt;
      cm_r    <= cm_nxt;
      end_r   <= end_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    cnt_r   <= cnt_nxt;
    bsn_r   <= bsn_nxt;
    hold_r  <= hold_nxt;
    kill_r  <= kill_nxt;
    first_r <= first_nxt;
    pend_r  <= pend_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign room = p_dist(end_r, rd_r) < PW'(BUF_DEPTH);
  assign k2   = (key_code == KEY_CR) ? KEY_NL : key_code;
  assign e1   = p_adv(end_r);

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    rd_nxt    = rd_r;
    cm_nxt    = cm_r;
    end_nxt   = end_r;
    cur_nxt   = cur_r;
    w_nxt     = w_r;
    cnt_nxt   = cnt_r;
    bsn_nxt   = bsn_r;
    hold_nxt  = hold_r;
    kill_nxt  = kill_r;
    first_nxt = first_r;
    pend_nxt  = pend_r;
    we        = 1'b0;
    waddr     = p_slot(end_r);
    wdata     = key_code;
    re        = 1'b0;
    raddr     = p_slot(rd_r);
    emit      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (kind) begin
            first_nxt = read_first;
            if (raw_mode) begin
              cm_nxt  = end_r;
              cur_nxt = end_r;
            end
            if (rd_r == (raw_mode ? end_r : cm_r)) begin
              pend_nxt  = '{vld: 1'b1, target: TGT_READER, data: 8'h00,
                            status: ST_NONE, last: 1'b1};
              state_nxt = S_EMIT;
            end else begin
              re        = 1'b1;
              state_nxt = S_RDATA;
            end
          end else if (raw_mode) begin
            if (room) begin
              we      = 1'b1;
              end_nxt = e1;
              cm_nxt  = e1;
              cur_nxt = e1;
            end
          end else if (key_code == KEY_ESC) begin
            ph_nxt = PH_ESC;
          end else if (key_code == KEY_LBR && ph_r == PH_ESC) begin
            ph_nxt = PH_CSI;
          end else if (ph_r == PH_CSI) begin
            ph_nxt = PH_NORMAL;
            if (key_code == KEY_LEFT && cur_r != cm_r) begin
              cur_nxt   = p_back(cur_r);
              pend_nxt  = '{vld: 1'b1, target: TGT_ECHO, data: KEY_BS,
                            status: ST_BYTE, last: 1'b1};
              state_nxt = S_EMIT;
            end else if (key_code == KEY_RGHT && cur_r != end_r) begin
              re        = 1'b1;
              raddr     = p_slot(cur_r);
              cur_nxt   = p_adv(cur_r);
              state_nxt = S_CDATA;
            end
          end else begin
            ph_nxt = PH_NORMAL;
            if (key_code == KEY_PROC) begin
              state_nxt = S_IDLE;
            end else if (key_code == KEY_KILL) begin
              bsn_nxt   = '0;
              kill_nxt  = 1'b1;
              state_nxt = S_KILL_RD;
            end else if (key_code == KEY_BS || key_code == KEY_DEL) begin
              if (cur_r != cm_r) begin
                cnt_nxt   = p_dist(end_r, cur_r);
                bsn_nxt   = p_dist(end_r, cur_r);
                w_nxt     = cur_r;
                end_nxt   = p_back(end_r);
                cur_nxt   = p_back(cur_r);
                kill_nxt  = 1'b0;
                state_nxt = S_BK_RD;
              end
            end else if (room) begin
              if (k2 == KEY_NL || k2 == KEY_EOF) begin
                we        = 1'b1;
                wdata     = k2;
                end_nxt   = e1;
                cm_nxt    = e1;
                cur_nxt   = e1;
                pend_nxt  = '{vld: 1'b1, target: TGT_ECHO, data: k2,
                              status: ST_BYTE, last: 1'b1};
                state_nxt = S_EMIT;
              end else if (k2 != 8'h00) begin
                cnt_nxt   = p_dist(end_r, cur_r);
                bsn_nxt   = p_dist(end_r, cur_r);
                w_nxt     = cur_r;
                hold_nxt  = k2;
                end_nxt   = e1;
                cur_nxt   = p_adv(cur_r);
                if (p_dist(e1, rd_r) == PW'(BUF_DEPTH)) cm_nxt = e1;
                state_nxt = S_INS_RD;
              end
            end
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit      = pend_r;
          state_nxt = S_IDLE;
        end
      end
      S_RDATA: begin
        if (out_free) begin
          emit.vld    = 1'b1;
          emit.target = TGT_READER;
          emit.last   = 1'b1;
          if (!raw_mode && rdata_r == KEY_EOF) begin
            emit.status = ST_EOF;
            if (first_r) rd_nxt = p_adv(rd_r);
          end else begin
            emit.data   = rdata_r;
            emit.status = (rdata_r == KEY_NL) ? ST_LINE : ST_BYTE;
            rd_nxt      = p_adv(rd_r);
          end
          state_nxt = S_IDLE;
        end
      end
      S_CDATA: begin
        if (out_free) begin
          emit      = '{vld: 1'b1, target: TGT_ECHO, data: rdata_r,
                        status: ST_BYTE, last: 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_INS_RD: begin
        if (cnt_r != '0) begin
          re    = 1'b1;
          raddr = p_slot(w_r);
        end
        state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        if (out_free) begin
          we       = 1'b1;
          waddr    = p_slot(w_r);
          wdata    = hold_r;
          emit     = '{vld: 1'b1, target: TGT_ECHO, data: hold_r, status: ST_BYTE,
                       last: (cnt_r == '0 && bsn_r == '0)};
          hold_nxt = rdata_r;
          w_nxt    = p_adv(w_r);
          if (cnt_r == '0) begin
            state_nxt = (bsn_r == '0) ? S_IDLE : S_BSN;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_INS_RD;
          end
        end
      end
      S_BSN: begin
        if (out_free) begin
          emit    = '{vld: 1'b1, target: TGT_ECHO, data: KEY_BS, status: ST_BYTE,
                      last: (bsn_r == PW'(1))};
          bsn_nxt = bsn_r - 1'b1;
          if (bsn_r == PW'(1)) state_nxt = S_IDLE;
        end
      end
      S_BK_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_RUB1;
        end else begin
          re        = 1'b1;
          raddr     = p_slot(w_r);
          state_nxt = S_BK_WR;
        end
      end
      S_BK_WR: begin
        if (out_free) begin
          we        = 1'b1;
          waddr     = p_slot(p_back(w_r));
          wdata     = rdata_r;
          emit      = '{vld: 1'b1, target: TGT_ECHO, data: rdata_r,
                        status: ST_BYTE, last: 1'b0};
          w_nxt     = p_adv(w_r);
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_BK_RD;
        end
      end
      S_RUB1: begin
        if (out_free) begin
          emit      = '{vld: 1'b1, target: TGT_ECHO, data: KEY_BS,
                        status: ST_BYTE, last: 1'b0};
          state_nxt = S_RUB2;
        end
      end
      S_RUB2: begin
        if (out_free) begin
          emit      = '{vld: 1'b1, target: TGT_ECHO, data: KEY_SP,
                        status: ST_BYTE, last: 1'b0};
          state_nxt = kill_r ? S_KILL_CHK : S_RUB3;
        end
      end
      S_RUB3: begin
        if (out_free) begin
          emit      = '{vld: 1'b1, target: TGT_ECHO, data: KEY_BS, status: ST_BYTE,
                        last: (bsn_r == '0)};
          state_nxt = (bsn_r == '0) ? S_IDLE : S_BSN;
        end
      end
      S_KILL_RD: begin
        if (end_r == cm_r) begin
          state_nxt = S_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = p_slot(p_back(end_r));
          state_nxt = S_KILL_EV;
        end
      end
      S_KILL_EV: begin
        if (rdata_r == KEY_NL) begin
          state_nxt = S_IDLE;
        end else begin
          end_nxt   = p_back(end_r);
          cur_nxt   = cm_r;
          state_nxt = S_RUB1;
        end
      end
      // look ahead one byte so the closing backspace knows if it ends the item
      S_KILL_CHK: begin
        if (end_r == cm_r) begin
          state_nxt = S_RUB3;
        end else begin
          re        = 1'b1;
          raddr     = p_slot(p_back(end_r));
          state_nxt = S_KILL_EV2;
        end
      end
      S_KILL_EV2: begin
        if (out_free) begin
          emit = '{vld: 1'b1, target: TGT_ECHO, data: KEY_BS, status: ST_BYTE,
                   last: (rdata_r == KEY_NL)};
          if (rdata_r == KEY_NL) begin
            state_nxt = S_IDLE;
          end else begin
            end_nxt   = p_back(end_r);
            cur_nxt   = cm_r;
            state_nxt = S_RUB1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== design/console_line_editor_top.sv =====
// console line editor: keystroke and read items in, echo and reader answers out
// flow: a raw keystroke is written into the store, if it has room, with no result; a read
// answer is read from the line store into a register, then held in the output register
// shifting: each shifted byte is a store read, then a write back; each redraw backspace
// is one output; write backs and outputs stall while the output register is full
// reset: synchronous active-low rst_n clears pointers, escape phase and output valid,
// raw mode comes up set; the line store is not cleared
module console_line_editor_top import cle_pkg::*; #(
  parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] key_code, [8] read_first, [15:9] zero
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] read_status, [15:10] zero
  output logic        out_tuser,  // [0] out_target
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic      raw_r;
  logic      idle;
  logic      out_free;
  cle_emit_t emit;
  logic      out_valid_r, out_valid_nxt;
  cle_emit_t out_r;

  assign cfg_ready = 1'b1;
  assign in_tready = idle;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r <= 1'b1;
    end else if (cfg_valid) begin
      raw_r <= cfg_data;
    end
  end

  cle_core #(.BUF_DEPTH(BUF_DEPTH)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_tvalid && idle),
    .kind       (in_tuser),
    .key_code   (in_tdata[7:0]),
    .read_first (in_tdata[8]),
    .raw_mode   (raw_r),
    .out_free   (out_free),
    .idle       (idle),
    .emit       (emit)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.vld) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (emit.vld) out_r <= emit;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.status, out_r.data};
  assign out_tuser  = out_r.target;
  assign out_tlast  = out_r.last;

endmodule

// ===== design/cle_checker.sv =====
// cle_checker: port-level assertions for the console line editor
// bound to console_line_editor_top; uses cle_pkg
module cle_checker import cle_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a read always has a result pending, so the input side closes
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("read transfer not followed by busy");

  a_reader_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == TGT_READER |-> out_tlast)
    else $error("reader answer not last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9:8] == ST_NONE || out_tdata[9:8] == ST_EOF)
      |-> out_tdata[7:0] == 8'h00 && out_tuser == TGT_READER)
    else $error("empty or eof answer carries a byte");

  a_echo_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == TGT_ECHO |-> out_tdata[9:8] == ST_BYTE)
    else $error("echo with nonzero status");

endmodule

bind console_line_editor_top cle_checker u_cle_checker (.*);
